/* rtl/alaf_pkg.sv */
// Package for the alarm level attack/decay filter.
// Holds the beat layouts, filter constants and derived widths.
// No dependencies; every other file in rtl/ refers to it by scoped name.
`default_nettype none

package alaf_pkg;

    // Filter constants
    localparam int STRETCH  = 4;          // level stretch factor
    localparam int ID_BITS  = 16;         // significant bits of an object id
    localparam int MAX_LVL  = 3;          // highest input alarm level

    localparam int LEVEL_W  = $clog2(MAX_LVL * STRETCH + 1);
    localparam int DIST_W   = 20;
    localparam int TTE_W    = 16;
    localparam int OBJ_W    = 16;

    localparam logic [DIST_W-1:0] FAR_AWAY = DIST_W'(1000000);
    localparam logic [OBJ_W-1:0]  ID_MASK  =
        (ID_BITS >= OBJ_W) ? {OBJ_W{1'b1}} : OBJ_W'((64'd1 << ID_BITS) - 64'd1);

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 64;

    // Input beat, last field in the lowest bits
    typedef struct packed {
        logic [6:0]        pad;
        logic [TTE_W-1:0]  tte_s;
        logic              tte_valid;
        logic [DIST_W-1:0] distance_m;
        logic              dist_valid;
        logic [OBJ_W-1:0]  object_id;
        logic [1:0]        alarm_level;
        logic              alarm_present;
    } in_item_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [4:0]        pad;
        logic [OBJ_W-1:0]  tracked_object;
        logic [TTE_W-1:0]  stored_tte;
        logic [DIST_W-1:0] stored_distance;
        logic              approaching_flag;
        logic [3:0]        filtered_level;
        logic [1:0]        reported_level;
    } out_item_t;

endpackage

`default_nettype wire

/* rtl/alaf_in_stage.sv */
// Input register stage of the alarm level filter.
// Captures one slave-side beat and holds it until the core takes it.
// Depends on alaf_pkg.
`default_nettype none

module alaf_in_stage (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [alaf_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                               advance,
    output logic                                    item_valid,
    output alaf_pkg::in_item_t                      item
);

    logic               valid_reg;
    alaf_pkg::in_item_t item_reg;

    // Take a new beat when empty or when the held one moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= alaf_pkg::in_item_t'(s_tdata);
        end
    end

endmodule

`default_nettype wire

/* rtl/alaf_core.sv */
// Filter state and single-pass update logic of the alarm level filter.
// Computes the next state and the result from one item; commits on step.
// Depends on alaf_pkg.
`default_nettype none

module alaf_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  alaf_pkg::in_item_t       item,
    output alaf_pkg::out_item_t      result
);

    logic [alaf_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic                         approach_reg, approach_next;
    logic [alaf_pkg::DIST_W-1:0]  distance_reg, distance_next;
    logic [alaf_pkg::TTE_W-1:0]   tte_reg, tte_next;
    logic [alaf_pkg::OBJ_W-1:0]   object_reg, object_next;

    logic [alaf_pkg::OBJ_W-1:0]   obj;
    logic [alaf_pkg::LEVEL_W-1:0] target;
    logic [alaf_pkg::LEVEL_W-1:0] gap;
    logic                         dv, tv;
    logic                         new_obj;
    logic                         appr_mid;
    logic [alaf_pkg::DIST_W-1:0]  dist_mid;
    logic [alaf_pkg::OBJ_W-1:0]   obj_mid;
    logic [1:0]                   rep;

    always_comb
    begin
        obj     = item.object_id & alaf_pkg::ID_MASK;
        dv      = item.alarm_present && item.dist_valid;
        tv      = item.alarm_present && item.tte_valid;
        target  = item.alarm_present
                ? alaf_pkg::LEVEL_W'(32'(item.alarm_level) * alaf_pkg::STRETCH)
                : '0;

        // Latch a new object: distance restarts far away, assume approach
        new_obj  = item.alarm_present && (obj != '0) && (obj != object_reg);
        obj_mid  = new_obj ? obj : object_reg;
        dist_mid = new_obj ? alaf_pkg::FAR_AWAY : distance_reg;
        appr_mid = new_obj ? 1'b1 : approach_reg;

        // Attack at once, decay by two when far above target, else by one
        gap = level_reg - target;
        if (target > level_reg)
        begin
            level_next = target;
        end
        else if (target < level_reg)
        begin
            if (gap > alaf_pkg::LEVEL_W'(alaf_pkg::STRETCH))
            begin
                level_next = level_reg - alaf_pkg::LEVEL_W'(2);
            end
            else
            begin
                level_next = level_reg - alaf_pkg::LEVEL_W'(1);
            end
        end
        else
        begin
            level_next = level_reg;
        end

        if (dv)
        begin
            approach_next = item.distance_m < dist_mid;
            distance_next = item.distance_m;
        end
        else
        begin
            approach_next = appr_mid;
            distance_next = dist_mid;
        end

        // Load a new time to encounter, else count it down to zero while closing in
        if (tv)
        begin
            tte_next = item.tte_s;
        end
        else if (approach_next && (tte_reg != '0))
        begin
            tte_next = tte_reg - alaf_pkg::TTE_W'(1);
        end
        else
        begin
            tte_next = tte_reg;
        end

        // Drop the object once the level has fully decayed
        object_next = (level_next == '0) ? '0 : obj_mid;

        if ((level_next != '0) && approach_next)
        begin
            rep = 2'((32'(level_next) + alaf_pkg::STRETCH - 1) / alaf_pkg::STRETCH);
        end
        else
        begin
            rep = 2'd0;
        end

        result                  = '0;
        result.reported_level   = rep;
        result.filtered_level   = 4'(level_next);
        result.approaching_flag = approach_next;
        result.stored_distance  = distance_next;
        result.stored_tte       = tte_next;
        result.tracked_object   = object_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            approach_reg <= 1'b0;
            distance_reg <= '0;
            tte_reg      <= '0;
            object_reg   <= '0;
        end
        else if (step)
        begin
            level_reg    <= level_next;
            approach_reg <= approach_next;
            distance_reg <= distance_next;
            tte_reg      <= tte_next;
            object_reg   <= object_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/alaf_out_stage.sv */
// Result register stage of the alarm level filter.
// Holds one result beat on the master side until it is taken.
// Depends on alaf_pkg.
`default_nettype none

module alaf_out_stage (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  alaf_pkg::out_item_t                     result,
    output logic                                    can_load,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [alaf_pkg::OUT_DATA_W-1:0]         m_tdata
);

    logic                valid_reg;
    alaf_pkg::out_item_t data_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = alaf_pkg::OUT_DATA_W'(data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

/* rtl/alarm_level_attack_decay_filter.sv */
// Top level of the alarm level attack/decay filter.
// Instantiates alaf_in_stage, alaf_core and alaf_out_stage; uses alaf_pkg.
//
//   Channel   Direction  Width  Contents
//   s_axis    in         64     one update: alarm, object, distance, time
//   m_axis    out        64     filtered level, approach, tracked object
//
// Each update beat yields exactly one result beat. The update is held in the
// input register and its result in the result register before m_axis shows it.
// One beat per cycle is sustained while m_tready is high: the filter state is
// read and rewritten in the same cycle as the held update moves from the input
// register into the result register.
// rst_n clears the filter state and both stage valid flags.
// A stalled m_tready holds the result register; the input register keeps
// taking beats until it too is full.
`default_nettype none

module alarm_level_attack_decay_filter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [0] alarm_present, [2:1] alarm_level, [18:3] object_id, [19] dist_valid,
    // [39:20] distance_m, [40] tte_valid, [56:41] tte_s, [63:57] zero
    input  wire logic [alaf_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [1:0] reported_level, [5:2] filtered_level, [6] approaching_flag,
    // [26:7] stored_distance, [42:27] stored_tte, [58:43] tracked_object,
    // [63:59] zero
    output logic [alaf_pkg::OUT_DATA_W-1:0]         m_tdata
);

    logic                item_valid;
    alaf_pkg::in_item_t  item;
    alaf_pkg::out_item_t result;
    logic                can_load;
    logic                advance;

    // Move the held update forward whenever the result register has room
    assign advance = item_valid && can_load;

    alaf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Commit the filter state in the same cycle the result is loaded
    alaf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .result (result)
    );

    alaf_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/alaf_checker.sv */
// Port-level checker for the alarm level attack/decay filter.
// Watches the master-side beats only; bound to the top level below.
// Depends on alaf_pkg.
`default_nettype none

module alaf_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [alaf_pkg::OUT_DATA_W-1:0]    m_tdata
);

    alaf_pkg::out_item_t beat;
    assign beat = alaf_pkg::out_item_t'(m_tdata);

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A nonzero report needs an approaching object and a nonzero level
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (beat.reported_level != 2'd0) |->
            beat.approaching_flag && (beat.filtered_level != 4'd0))
        else $error("report without approach or level");

    // Reported level is the rounded-up filtered level while approaching
    a_round: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && beat.approaching_flag && (beat.filtered_level != 4'd0) |->
            beat.reported_level == 2'((32'(beat.filtered_level) + alaf_pkg::STRETCH - 1)
                                      / alaf_pkg::STRETCH))
        else $error("reported level does not match filtered level");

    // A fully decayed level drops the tracked object
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (beat.filtered_level == 4'd0) |-> beat.tracked_object == '0)
        else $error("object kept at level zero");

endmodule

bind alarm_level_attack_decay_filter alaf_checker u_alaf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
